[rtl/nfea_pkg.sv]
`timescale 1ns / 1ps
// nfea_pkg: shared types, codes and helpers of the next-fit extent allocator
// used by next_fit_extent_allocator and nfea_checker; no dependencies

package nfea_pkg;

  // fixed field widths of the item and result ports
  localparam int CFG_W      = 11;
  localparam int OWNER_IN_W = 16;
  localparam int EXT_IN_W   = 10;
  localparam int STATUS_W   = 3;
  localparam int GRANT_W    = 10;
  localparam int COUNT_W    = 11;

  // bitmap word geometry for the free-bit scan
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BUSY    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_UNSET   = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCHK,
    ST_OWN_RD,
    ST_OWN_CHK,
    ST_FREE_RD,
    ST_FREE_WR
  } nfea_state_e;

  // index of the lowest set bit of a bitmap word, zero when none is set
  function automatic logic [OFF_W-1:0] nfea_ffs(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = OFF_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/next_fit_extent_allocator.sv]
`timescale 1ns / 1ps
// next_fit_extent_allocator: top level, sequencer, bitmap and owner memories
// depends on nfea_pkg

// Next-fit extent allocator. An item is taken when start is high and busy is
// low; its one result appears on status_o, granted_extent_o and
// stored_count_o for a single cycle marked by done_o, and cannot be held off.
// After reset the block sweeps the owner memory and the bitmap clear, one
// entry a cycle, and stays busy until the sweep is done; cfg writes are taken
// at all times (cfg_ready_o is always high). A rejected item (zero owner,
// extent out of range, bound of zero) gives its result the cycle after it is
// taken and leaves busy low. A free reads the bitmap word, then clears the bit
// and the owner. An allocate scans W 32-bit bitmap words, reading and
// checking one word at a time through the single bitmap read port, then
// reads the owner entry and claims it if free: W is 1 when the word holding
// the last allocated position has a free bit at or above it, and at most
// 2*ceil(B/32) when the scan wraps, B being the cfg bound clipped to MAX_EXTENTS.

module next_fit_extent_allocator
  import nfea_pkg::*;
#(
  parameter int MAX_EXTENTS = 1024,
  parameter int OWNER_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic [OWNER_IN_W-1:0] owner_id_i,
  input  logic [EXT_IN_W-1:0]   extent_id_i,
  // result channel
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [GRANT_W-1:0]    granted_extent_o,
  output logic [COUNT_W-1:0]    stored_count_o,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int IDX_W   = $clog2(MAX_EXTENTS);
  localparam int NWORDS  = (MAX_EXTENTS + WORD_W - 1) / WORD_W;
  localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BI_W    = WA_W + OFF_W;
  localparam int PW      = BI_W + 1;
  localparam int CW      = (PW > CFG_W) ? PW : CFG_W;
  localparam int OX_W    = (OWNER_BITS > OWNER_IN_W) ? OWNER_BITS : OWNER_IN_W;
  localparam int LIM_RST = (MAX_EXTENTS < 1024) ? MAX_EXTENTS : 1024;

  // state and datapath registers
  nfea_state_e            state_q, state_d;
  logic [IDX_W-1:0]       clr_q, clr_d;
  logic [PW-1:0]          lim_q, lim_d;
  logic [BI_W-1:0]        last_q, last_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [WA_W-1:0]        waddr_q, waddr_d;
  logic [OFF_W-1:0]       off_q, off_d;
  logic                   first_q, first_d;
  logic                   pass_q, pass_d;
  logic                   startnz_q, startnz_d;
  logic [BI_W-1:0]        b_q, b_d;
  logic [IDX_W-1:0]       ext_q, ext_d;
  logic [OWNER_BITS-1:0]  owner_q, owner_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [GRANT_W-1:0]     res_grant_q, res_grant_d;
  logic [COUNT_W-1:0]     res_count_q, res_count_d;

  // memory ports
  logic                   bm_we;
  logic [WA_W-1:0]        bm_wa, bm_ra;
  logic [WORD_W-1:0]      bm_wd, bm_rd_q;
  logic                   own_we;
  logic [IDX_W-1:0]       own_a;
  logic [OWNER_BITS-1:0]  own_wd, own_rd_q;

  logic [WORD_W-1:0]      bm_mem [NWORDS];
  logic [OWNER_BITS-1:0]  own_mem [MAX_EXTENTS];

  // helper terms
  logic [OX_W-1:0]        owner_in_x;
  logic [OWNER_BITS-1:0]  owner_in;
  logic [CW-1:0]          cfg_x;
  logic [CW-1:0]          lim_word;
  logic [CW-1:0]          next_base;
  logic [WORD_W-1:0]      lo_mask, lim_mask, cand, bit_mask;
  logic [OFF_W-1:0]       found_off;
  logic [IDX_W-1:0]       ext_calc;
  logic [BI_W-1:0]        b_free;
  logic [COUNT_W-1:0]     cnt_inc, cnt_dec;

  assign busy             = (state_q != ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign done_o           = done_q;
  assign status_o         = res_status_q;
  assign granted_extent_o = res_grant_q;
  assign stored_count_o   = res_count_q;

  // search bound: register value clipped to the capacity
  assign cfg_x = CW'(cfg_data_i);
  assign lim_d = (cfg_x > CW'(MAX_EXTENTS)) ? PW'(MAX_EXTENTS) : PW'(cfg_x);

  // owner masked to its stored width
  assign owner_in_x = OX_W'(owner_id_i);
  assign owner_in   = owner_in_x[OWNER_BITS-1:0];

  // scan candidates in the current word
  assign lo_mask   = first_q ? ({WORD_W{1'b1}} << off_q) : {WORD_W{1'b1}};
  assign lim_word  = CW'(lim_q) >> OFF_W;
  assign lim_mask  = (CW'(waddr_q) == lim_word) ?
                     ~({WORD_W{1'b1}} << lim_q[OFF_W-1:0]) : {WORD_W{1'b1}};
  assign cand      = ~bm_rd_q & lo_mask & lim_mask;
  assign found_off = nfea_ffs(cand);
  assign next_base = CW'((CW'(waddr_q) + CW'(1)) << OFF_W);

  // bit position to extent id and back
  assign ext_calc = IDX_W'(CW'(lim_q) - CW'(b_q) - CW'(1));
  assign b_free   = BI_W'(CW'(lim_q) - CW'(extent_id_i) - CW'(1));
  assign bit_mask = WORD_W'(1) << b_q[OFF_W-1:0];

  // saturating count steps
  assign cnt_inc = (cnt_q == {COUNT_W{1'b1}}) ? cnt_q : cnt_q + COUNT_W'(1);
  assign cnt_dec = (cnt_q == '0) ? cnt_q : cnt_q - COUNT_W'(1);

  // sequencer: next state, datapath updates and memory controls
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    done_d       = 1'b0;
    waddr_d      = waddr_q;
    off_d        = off_q;
    first_d      = first_q;
    pass_d       = pass_q;
    startnz_d    = startnz_q;
    b_d          = b_q;
    ext_d        = ext_q;
    owner_d      = owner_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    res_count_d  = res_count_q;
    bm_we        = 1'b0;
    bm_wa        = waddr_q;
    bm_wd        = '0;
    bm_ra        = waddr_q;
    own_we       = 1'b0;
    own_a        = ext_q;
    own_wd       = '0;
    unique case (state_q)
      // clearing sweep after reset
      ST_CLEAR: begin
        own_we = 1'b1;
        own_a  = clr_q;
        if (CW'(clr_q) < CW'(NWORDS)) begin
          bm_we = 1'b1;
          bm_wa = WA_W'(clr_q);
        end
        if (clr_q == IDX_W'(MAX_EXTENTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      // take an item and sort out the rejected cases at once
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACT_ALLOC) begin
            owner_d = owner_in;
            if (owner_in == '0) begin
              done_d       = 1'b1;
              res_status_d = STAT_INVALID;
              res_grant_d  = '0;
              res_count_d  = cnt_q;
            end else if (lim_q == '0) begin
              done_d       = 1'b1;
              res_status_d = STAT_NOSPACE;
              res_grant_d  = '0;
              res_count_d  = cnt_q;
            end else if (PW'(last_q) >= lim_q) begin
              // start beyond bound: go straight to the wrapped pass
              pass_d    = 1'b1;
              startnz_d = 1'b1;
              waddr_d   = '0;
              first_d   = 1'b0;
              state_d   = ST_SCAN;
            end else begin
              pass_d    = 1'b0;
              startnz_d = (last_q != '0);
              waddr_d   = last_q[BI_W-1:OFF_W];
              off_d     = last_q[OFF_W-1:0];
              first_d   = 1'b1;
              state_d   = ST_SCAN;
            end
          end else begin
            res_grant_d = extent_id_i;
            if (CW'(extent_id_i) >= CW'(lim_q)) begin
              done_d       = 1'b1;
              res_status_d = STAT_INVALID;
              res_count_d  = cnt_q;
            end else begin
              b_d     = b_free;
              ext_d   = IDX_W'(extent_id_i);
              state_d = ST_FREE_RD;
            end
          end
        end
      end
      // read one bitmap word
      ST_SCAN: begin
        bm_ra   = waddr_q;
        state_d = ST_SCHK;
      end
      // look for a clear bit, else step on, wrap once or give up
      ST_SCHK: begin
        if (|cand) begin
          b_d     = {waddr_q, found_off};
          state_d = ST_OWN_RD;
        end else if (next_base < CW'(lim_q)) begin
          waddr_d = waddr_q + WA_W'(1);
          first_d = 1'b0;
          state_d = ST_SCAN;
        end else if (!pass_q && startnz_q) begin
          pass_d  = 1'b1;
          waddr_d = '0;
          first_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          done_d       = 1'b1;
          res_status_d = STAT_NOSPACE;
          res_grant_d  = '0;
          res_count_d  = cnt_q;
          state_d      = ST_IDLE;
        end
      end
      // read the owner of the extent found
      ST_OWN_RD: begin
        ext_d   = ext_calc;
        own_a   = ext_calc;
        state_d = ST_OWN_CHK;
      end
      // busy extent or claim it; the bitmap word read still sits at waddr_q
      ST_OWN_CHK: begin
        done_d      = 1'b1;
        res_grant_d = GRANT_W'(ext_q);
        state_d     = ST_IDLE;
        if (own_rd_q != '0) begin
          res_status_d = STAT_BUSY;
          res_count_d  = cnt_q;
        end else begin
          own_we       = 1'b1;
          own_a        = ext_q;
          own_wd       = owner_q;
          bm_we        = 1'b1;
          bm_wa        = waddr_q;
          bm_wd        = bm_rd_q | bit_mask;
          last_d       = b_q;
          cnt_d        = cnt_inc;
          res_status_d = STAT_OK;
          res_count_d  = cnt_inc;
        end
      end
      // read the word holding the bit to free
      ST_FREE_RD: begin
        bm_ra   = b_q[BI_W-1:OFF_W];
        state_d = ST_FREE_WR;
      end
      // clear owner and bit, flag a bit that was not set
      ST_FREE_WR: begin
        bm_ra        = b_q[BI_W-1:OFF_W];
        bm_we        = 1'b1;
        bm_wa        = b_q[BI_W-1:OFF_W];
        bm_wd        = bm_rd_q & ~bit_mask;
        own_we       = 1'b1;
        own_a        = ext_q;
        own_wd       = '0;
        cnt_d        = cnt_dec;
        done_d       = 1'b1;
        res_status_d = (|(bm_rd_q & bit_mask)) ? STAT_OK : STAT_UNSET;
        res_count_d  = cnt_dec;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      lim_q   <= PW'(LIM_RST);
      last_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        lim_q <= lim_d;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    waddr_q      <= waddr_d;
    off_q        <= off_d;
    first_q      <= first_d;
    pass_q       <= pass_d;
    startnz_q    <= startnz_d;
    b_q          <= b_d;
    ext_q        <= ext_d;
    owner_q      <= owner_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    res_count_q  <= res_count_d;
  end

  // occupancy bitmap, one word per entry
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    bm_rd_q <= bm_mem[bm_ra];
  end

  // owner tags, one per extent
  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[own_a] <= own_wd;
    end
    own_rd_q <= own_mem[own_a];
  end

endmodule

[rtl/nfea_checker.sv]
`timescale 1ns / 1ps
// nfea_checker: port-level assertions for next_fit_extent_allocator
// depends on nfea_pkg; bound to the top level at the end of this file

module nfea_checker
  import nfea_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [GRANT_W-1:0]  granted_extent_o
);

  // a taken item either answers at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("taken item neither answered nor worked on");

  // a result only shows once the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // every result follows an accepted item or a stretch of work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an item");

  // no-space results carry extent zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_NOSPACE)) |-> (granted_extent_o == '0))
    else $error("no-space result with an extent");

endmodule

bind next_fit_extent_allocator nfea_checker u_nfea_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .status_o         (status_o),
  .granted_extent_o (granted_extent_o)
);
